### hdl/gn2d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gn2d_pkg;

    // Grid size defaults and the gradient table geometry.
    localparam int GRID_W_DEF  = 128;
    localparam int GRID_H_DEF  = 128;
    localparam int TABLE_DEPTH = 16384;
    localparam int TABLE_AW    = 14;

    // Field widths.
    localparam int FREQ_W  = 17;
    localparam int PIX_W   = 16;
    localparam int GRAD_W  = 16;
    localparam int FRAC_W  = 16;
    localparam int DOT_W   = 34;
    localparam int NOISE_W = 16;
    localparam int GRAY_W  = 8;

    localparam logic [FREQ_W-1:0] FREQ_RESET = 17'd6554;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } gn2d_op_t;

    // Table addresses of the four cell corners.
    typedef struct packed {
        logic [TABLE_AW-1:0] a00;
        logic [TABLE_AW-1:0] a10;
        logic [TABLE_AW-1:0] a01;
        logic [TABLE_AW-1:0] a11;
    } gn2d_addr_t;

    // Cell fractions and their smoothstep weights, all Q0.16.
    typedef struct packed {
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
        logic [FRAC_W-1:0] sx;
        logic [FRAC_W-1:0] sy;
    } gn2d_frac_t;

    // One stored gradient pair, Q1.14.
    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
    } gn2d_grad_t;

endpackage

`default_nettype wire

### hdl/gn2d_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gn2d_in_if import gn2d_pkg::*; ();
    logic                     valid;
    logic                     ready;
    gn2d_op_t                 operation;
    logic [TABLE_AW-1:0]      grid_index;
    logic signed [GRAD_W-1:0] gradient_x_in;
    logic signed [GRAD_W-1:0] gradient_y_in;
    logic [PIX_W-1:0]         pixel_x;
    logic [PIX_W-1:0]         pixel_y;

    modport source (
        output valid, operation, grid_index, gradient_x_in, gradient_y_in,
               pixel_x, pixel_y,
        input  ready
    );
    modport sink (
        input  valid, operation, grid_index, gradient_x_in, gradient_y_in,
               pixel_x, pixel_y,
        output ready
    );
endinterface

interface gn2d_out_if import gn2d_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [NOISE_W-1:0] noise_value;
    logic [GRAY_W-1:0]         gray_level;

    modport source (output valid, noise_value, gray_level, input ready);
    modport sink (input valid, noise_value, gray_level, output ready);
endinterface

interface gn2d_cfg_if import gn2d_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] frequency;

    modport source (output valid, frequency, input ready);
    modport sink (input valid, frequency, output ready);
endinterface

`default_nettype wire

### hdl/gn2d_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module gn2d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hdl/gn2d_coord.sv
`timescale 1ns / 1ps
`default_nettype none

module gn2d_coord import gn2d_pkg::*; #(
    parameter int GRID_W = GRID_W_DEF,
    parameter int GRID_H = GRID_H_DEF
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [PIX_W-1:0]  pixel_x,
    input  wire logic [PIX_W-1:0]  pixel_y,
    input  wire logic [FREQ_W-1:0] frequency,
    output gn2d_addr_t             addr,
    output gn2d_frac_t             frac
);

    localparam int XW = $clog2(GRID_W);
    localparam int YW = $clog2(GRID_H);
    localparam int NW = 17;
    localparam int ROW_W = 24;
    // Reciprocals in Q0.17; the quotient estimate is low by at most one.
    localparam logic [NW-1:0] RECIP_X = NW'((64'd1 << NW) / GRID_W);
    localparam logic [NW-1:0] RECIP_Y = NW'((64'd1 << NW) / GRID_H);

    // Stage 1: scaled coordinates, Q17.16.
    logic [32:0] cx_reg, cy_reg;
    // Stage 2: integer parts, quotient estimates, fractions, fraction squares.
    logic [NW-1:0]     nx_reg, ny_reg, qx_reg, qy_reg;
    logic [FRAC_W-1:0] fx2_reg, fy2_reg;
    logic [31:0]       ttx_reg, tty_reg;
    // Stage 3: wrapped cells and weights.
    logic [XW-1:0]     ix_reg, ix1_reg;
    logic [YW-1:0]     iy_reg, iy1_reg;
    logic [FRAC_W-1:0] fx3_reg, fy3_reg, sx3_reg, sy3_reg;
    // Stage 4: corner addresses.
    gn2d_addr_t addr_reg;
    gn2d_frac_t frac_reg;

    logic [2*NW-1:0] qx_prod, qy_prod;
    logic [NW:0]     rx, ry, rx_fix, ry_fix;
    logic [27:0]     qwx, qwy;
    logic [17:0]     kx, ky;
    logic [49:0]     smx, smy;
    logic [XW-1:0]   ix_next, ix1_next;
    logic [YW-1:0]   iy_next, iy1_next;
    logic [ROW_W-1:0] row0, row1;

    always_comb
    begin
        qx_prod = (2*NW)'(cx_reg[32:16]) * (2*NW)'(RECIP_X);
        qy_prod = (2*NW)'(cy_reg[32:16]) * (2*NW)'(RECIP_Y);

        qwx = 28'(qx_reg) * 28'(GRID_W);
        qwy = 28'(qy_reg) * 28'(GRID_H);
        rx  = (NW+1)'(nx_reg) - qwx[NW:0];
        ry  = (NW+1)'(ny_reg) - qwy[NW:0];
        rx_fix = (rx >= (NW+1)'(GRID_W)) ? rx - (NW+1)'(GRID_W) : rx;
        ry_fix = (ry >= (NW+1)'(GRID_H)) ? ry - (NW+1)'(GRID_H) : ry;
        ix_next  = XW'(rx_fix);
        iy_next  = YW'(ry_fix);
        ix1_next = (ix_next == XW'(GRID_W - 1)) ? '0 : XW'(ix_next + 1'b1);
        iy1_next = (iy_next == YW'(GRID_H - 1)) ? '0 : YW'(iy_next + 1'b1);

        // Smoothstep t*t*(3 - 2t) with t in Q0.16.
        kx  = 18'd196608 - {1'b0, fx2_reg, 1'b0};
        ky  = 18'd196608 - {1'b0, fy2_reg, 1'b0};
        smx = 50'(ttx_reg) * 50'(kx);
        smy = 50'(tty_reg) * 50'(ky);

        row0 = ROW_W'(iy_reg) * ROW_W'(GRID_W);
        row1 = ROW_W'(iy1_reg) * ROW_W'(GRID_W);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg <= 33'(pixel_x) * 33'(frequency);
            cy_reg <= 33'(pixel_y) * 33'(frequency);

            nx_reg  <= cx_reg[32:16];
            ny_reg  <= cy_reg[32:16];
            qx_reg  <= qx_prod[2*NW-1:NW];
            qy_reg  <= qy_prod[2*NW-1:NW];
            fx2_reg <= cx_reg[15:0];
            fy2_reg <= cy_reg[15:0];
            ttx_reg <= 32'(cx_reg[15:0]) * 32'(cx_reg[15:0]);
            tty_reg <= 32'(cy_reg[15:0]) * 32'(cy_reg[15:0]);

            ix_reg  <= ix_next;
            ix1_reg <= ix1_next;
            iy_reg  <= iy_next;
            iy1_reg <= iy1_next;
            fx3_reg <= fx2_reg;
            fy3_reg <= fy2_reg;
            sx3_reg <= smx[47:32];
            sy3_reg <= smy[47:32];

            addr_reg.a00 <= TABLE_AW'(row0 + ROW_W'(ix_reg));
            addr_reg.a10 <= TABLE_AW'(row0 + ROW_W'(ix1_reg));
            addr_reg.a01 <= TABLE_AW'(row1 + ROW_W'(ix_reg));
            addr_reg.a11 <= TABLE_AW'(row1 + ROW_W'(ix1_reg));
            frac_reg.fx  <= fx3_reg;
            frac_reg.fy  <= fy3_reg;
            frac_reg.sx  <= sx3_reg;
            frac_reg.sy  <= sy3_reg;
        end
    end

    assign addr = addr_reg;
    assign frac = frac_reg;

endmodule

`default_nettype wire

### hdl/gn2d_blend.sv
`timescale 1ns / 1ps
`default_nettype none

module gn2d_blend import gn2d_pkg::*; (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire gn2d_grad_t          g00,
    input  wire gn2d_grad_t          g10,
    input  wire gn2d_grad_t          g01,
    input  wire gn2d_grad_t          g11,
    input  wire gn2d_frac_t          frac,
    output logic signed [NOISE_W-1:0] noise_value,
    output logic        [GRAY_W-1:0]  gray_level
);

    localparam int PW = DOT_W + 1 + FRAC_W + 1;

    logic signed [DOT_W-1:0] d00_reg, d10_reg, d01_reg, d11_reg;
    logic [FRAC_W-1:0]       sx6_reg, sy6_reg, sy7_reg, sy8_reg;
    logic signed [DOT_W-1:0] d00_7_reg, d01_7_reg;
    logic signed [PW-1:0]    pa_reg, pb_reg;
    logic signed [DOT_W-1:0] a_reg, b_reg, a9_reg, v_reg;
    logic signed [PW-1:0]    pv_reg;
    logic signed [NOISE_W-1:0] noise_reg;
    logic [GRAY_W-1:0]       gray_reg;

    logic signed [16:0]     dx0, dx1, dy0, dy1;
    logic signed [DOT_W:0]  diff_a, diff_b, diff_v;
    logic signed [PW-1:0]   pa_sh, pb_sh, pv_sh;
    logic signed [DOT_W-1:0] v_clamp;
    logic [30:0]            u;
    logic [38:0]            u255;

    function automatic logic signed [DOT_W-1:0] dot(
        input gn2d_grad_t g,
        input logic signed [16:0] dx,
        input logic signed [16:0] dy
    );
        logic signed [DOT_W-1:0] px, py;
        px = DOT_W'($signed(g.gx)) * DOT_W'(dx);
        py = DOT_W'($signed(g.gy)) * DOT_W'(dy);
        return px + py;
    endfunction

    always_comb
    begin
        dx0 = $signed({1'b0, frac.fx});
        dx1 = $signed({1'b1, frac.fx});
        dy0 = $signed({1'b0, frac.fy});
        dy1 = $signed({1'b1, frac.fy});

        diff_a = (DOT_W+1)'(d10_reg) - (DOT_W+1)'(d00_reg);
        diff_b = (DOT_W+1)'(d11_reg) - (DOT_W+1)'(d01_reg);
        pa_sh  = pa_reg >>> FRAC_W;
        pb_sh  = pb_reg >>> FRAC_W;
        diff_v = (DOT_W+1)'(b_reg) - (DOT_W+1)'(a_reg);
        pv_sh  = pv_reg >>> FRAC_W;

        if (v_reg < -(DOT_W'(1) <<< 30))
        begin
            v_clamp = -(DOT_W'(1) <<< 30);
        end
        else if (v_reg > (DOT_W'(1) <<< 30) - DOT_W'(1))
        begin
            v_clamp = (DOT_W'(1) <<< 30) - DOT_W'(1);
        end
        else
        begin
            v_clamp = v_reg;
        end
        u    = 31'(v_clamp + (DOT_W'(1) <<< 30));
        u255 = {u, 8'd0} - 39'(u);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d00_reg <= dot(g00, dx0, dy0);
            d10_reg <= dot(g10, dx1, dy0);
            d01_reg <= dot(g01, dx0, dy1);
            d11_reg <= dot(g11, dx1, dy1);
            sx6_reg <= frac.sx;
            sy6_reg <= frac.sy;

            pa_reg    <= PW'(diff_a) * PW'($signed({1'b0, sx6_reg}));
            pb_reg    <= PW'(diff_b) * PW'($signed({1'b0, sx6_reg}));
            d00_7_reg <= d00_reg;
            d01_7_reg <= d01_reg;
            sy7_reg   <= sy6_reg;

            a_reg   <= DOT_W'(d00_7_reg + pa_sh);
            b_reg   <= DOT_W'(d01_7_reg + pb_sh);
            sy8_reg <= sy7_reg;

            pv_reg <= PW'(diff_v) * PW'($signed({1'b0, sy8_reg}));
            a9_reg <= a_reg;

            v_reg <= DOT_W'(a9_reg + pv_sh);

            noise_reg <= $signed({~u[30], u[29:15]});
            gray_reg  <= u255[38:31];
        end
    end

    assign noise_value = noise_reg;
    assign gray_level  = gray_reg;

endmodule

`default_nettype wire

### hdl/gradient_noise_2d_pixel.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel     Dir  Payload                                      Item
// pixel_in    in   operation, grid_index, gradient_x_in/y_in,   one load or one pixel
//                  pixel_x, pixel_y
// result_out  out  noise_value (Q1.15), gray_level              one evaluated pixel
// cfg         in   frequency (Q1.16, 17 bits)                   one register write
//
// One item enters per cycle while pixel_in.ready is high; a pixel result leaves
// through the output register, and a load item writes the gradient tables at the table stage.
// The rate rests on four replicated table copies, one read port per corner.
// Reset clears valid bits, the output stage and the frequency register (to 6554);
// the tables keep no reset state. A stall on result_out freezes the whole pipeline
// only once the skid register is full, so pixel_in.ready is a registered signal.

module gradient_noise_2d_pixel import gn2d_pkg::*; #(
    parameter int GRID_W = GRID_W_DEF,
    parameter int GRID_H = GRID_H_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    gn2d_in_if.sink      pixel_in,
    gn2d_out_if.source   result_out,
    gn2d_cfg_if.sink     cfg
);

    // Pipeline depth: stage 4 writes or reads the tables, stage 11 holds the result.
    localparam int WR_STAGE = 4;
    localparam int LAST     = 11;

    logic en;

    // Valid and operation bits travel with every stage.
    logic [LAST:1] vld_reg;
    logic [LAST:1] eval_reg;

    // Load payload rides along until the table stage.
    logic [TABLE_AW-1:0] ld_idx_reg [1:WR_STAGE];
    gn2d_grad_t          ld_grad_reg [1:WR_STAGE];

    logic [FREQ_W-1:0] freq_reg;

    gn2d_addr_t addr;
    gn2d_frac_t frac4, frac5_reg;

    logic [TABLE_AW-1:0] rd_addr [4];
    logic [2*GRAD_W-1:0] rd_data [4];
    logic                tbl_we;

    logic signed [NOISE_W-1:0] noise_s;
    logic [GRAY_W-1:0]         gray_s;

    // Output register plus one skid entry.
    logic                      out_valid_reg, skid_valid_reg;
    logic signed [NOISE_W-1:0] out_noise_reg, skid_noise_reg;
    logic [GRAY_W-1:0]         out_gray_reg, skid_gray_reg;
    logic                      out_take, leaving;

    assign en = !skid_valid_reg;
    assign pixel_in.ready = en;

    // The user must write the frequency register only while the pipeline is empty; no check.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= FREQ_RESET;
        end
        else if (cfg.valid)
        begin
            freq_reg <= cfg.frequency;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            eval_reg <= '0;
        end
        else if (en)
        begin
            vld_reg  <= {vld_reg[LAST-1:1], pixel_in.valid};
            eval_reg <= {eval_reg[LAST-1:1], pixel_in.operation == OP_EVAL};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ld_idx_reg[1]     <= pixel_in.grid_index;
            ld_grad_reg[1].gx <= pixel_in.gradient_x_in;
            ld_grad_reg[1].gy <= pixel_in.gradient_y_in;
            for (int i = 2; i <= WR_STAGE; i++)
            begin
                ld_idx_reg[i]  <= ld_idx_reg[i-1];
                ld_grad_reg[i] <= ld_grad_reg[i-1];
            end
            frac5_reg <= frac4;
        end
    end

    gn2d_coord #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H)
    ) u_coord (
        .clk       (clk),
        .en        (en),
        .pixel_x   (pixel_in.pixel_x),
        .pixel_y   (pixel_in.pixel_y),
        .frequency (freq_reg),
        .addr      (addr),
        .frac      (frac4)
    );

    // Every copy takes every load, so each corner has a read port of its own.
    assign tbl_we = en && vld_reg[WR_STAGE] && !eval_reg[WR_STAGE];
    assign rd_addr[0] = addr.a00;
    assign rd_addr[1] = addr.a10;
    assign rd_addr[2] = addr.a01;
    assign rd_addr[3] = addr.a11;

    for (genvar c = 0; c < 4; c++)
    begin : g_bank
        gn2d_ram #(
            .WIDTH (2*GRAD_W),
            .DEPTH (TABLE_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (tbl_we),
            .waddr (ld_idx_reg[WR_STAGE]),
            .wdata (ld_grad_reg[WR_STAGE]),
            .re    (en),
            .raddr (rd_addr[c]),
            .rdata (rd_data[c])
        );
    end

    gn2d_blend u_blend (
        .clk         (clk),
        .en          (en),
        .g00         (gn2d_grad_t'(rd_data[0])),
        .g10         (gn2d_grad_t'(rd_data[1])),
        .g01         (gn2d_grad_t'(rd_data[2])),
        .g11         (gn2d_grad_t'(rd_data[3])),
        .frac        (frac5_reg),
        .noise_value (noise_s),
        .gray_level  (gray_s)
    );

    assign out_take = out_valid_reg && result_out.ready;
    assign leaving  = en && vld_reg[LAST] && eval_reg[LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (leaving)
        begin
            if (out_valid_reg && !result_out.ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_noise_reg <= skid_noise_reg;
                out_gray_reg  <= skid_gray_reg;
            end
        end
        else if (leaving)
        begin
            if (out_valid_reg && !result_out.ready)
            begin
                skid_noise_reg <= noise_s;
                skid_gray_reg  <= gray_s;
            end
            else
            begin
                out_noise_reg <= noise_s;
                out_gray_reg  <= gray_s;
            end
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.noise_value = out_noise_reg;
    assign result_out.gray_level  = out_gray_reg;

endmodule

`default_nettype wire

### dv/tb_gradient_noise_2d_pixel.sv
`timescale 1ns / 1ps

module tb_gradient_noise_2d_pixel;
    import gn2d_pkg::*;

    localparam int GW = GRID_W_DEF;
    localparam int GH = GRID_H_DEF;
    localparam int DRAIN_CYCLES = 40;
    localparam int FILL_ROWS = 16;
    localparam int FILL_COLS = 16;

    // Noise result as the block delivers it.
    typedef struct {
        logic signed [NOISE_W-1:0] noise;
        logic [GRAY_W-1:0]         gray;
    } noise_res_t;

    logic clk;
    logic rst_n;

    gn2d_in_if  pix_if ();
    gn2d_out_if res_if ();
    gn2d_cfg_if cfg_if ();

    gradient_noise_2d_pixel i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_in   (pix_if),
        .result_out (res_if),
        .cfg        (cfg_if)
    );

    // Shadow copy of the gradient tables, the frequency register and a
    // record of which entries hold a gradient, so that no evaluate item
    // ever touches an entry that was never loaded.
    logic signed [GRAD_W-1:0] shadow_gx [TABLE_DEPTH];
    logic signed [GRAD_W-1:0] shadow_gy [TABLE_DEPTH];
    bit                       loaded [TABLE_DEPTH];
    logic [FREQ_W-1:0]        shadow_freq;

    noise_res_t pending_noise [$];
    int         mismatches;
    int         send_idle_pct;
    int         recv_stall_pct;

    always #5 clk = ~clk;

    // Smoothstep weight s = t*t*(3 - 2t) in Q0.16.
    function automatic longint smooth_weight(longint t);
        longint tt;
        longint k;
        tt = t * t;
        k  = 3 * 65536 - 2 * t;
        return (tt * k) >>> 32;
    endfunction

    // Lerp a + floor((b - a) * s / 2^16); arithmetic shift floors.
    function automatic longint lerp_q16(longint a, longint b, longint s);
        return a + (((b - a) * s) >>> 16);
    endfunction

    function automatic longint corner_dot(int addr, longint dx, longint dy);
        int m;
        m = addr % TABLE_DEPTH;
        return longint'(shadow_gx[m]) * dx + longint'(shadow_gy[m]) * dy;
    endfunction

    function automatic noise_res_t predict_noise(logic [15:0] px, logic [15:0] py);
        longint cx, cy, fx, fy, sx, sy, a, b, v, u;
        int     ix, iy, ix1, iy1;
        noise_res_t r;
        cx  = longint'(px) * longint'(shadow_freq);
        cy  = longint'(py) * longint'(shadow_freq);
        ix  = int'((cx >> 16) % GW);
        iy  = int'((cy >> 16) % GH);
        ix1 = (ix + 1) % GW;
        iy1 = (iy + 1) % GH;
        fx  = cx & 64'hFFFF;
        fy  = cy & 64'hFFFF;
        sx  = smooth_weight(fx);
        sy  = smooth_weight(fy);
        a = lerp_q16(corner_dot(iy * GW + ix, fx, fy),
                     corner_dot(iy * GW + ix1, fx - 65536, fy), sx);
        b = lerp_q16(corner_dot(iy1 * GW + ix, fx, fy - 65536),
                     corner_dot(iy1 * GW + ix1, fx - 65536, fy - 65536), sx);
        v = lerp_q16(a, b, sy);
        if (v < -(64'sd1 <<< 30))
            v = -(64'sd1 <<< 30);
        if (v > (64'sd1 <<< 30) - 1)
            v = (64'sd1 <<< 30) - 1;
        u = v + (64'sd1 <<< 30);
        r.noise = NOISE_W'((u >> 15) - 32768);
        r.gray  = GRAY_W'((u * 255) >> 31);
        return r;
    endfunction

    // True when all four corners of the pixel's cell hold a gradient.
    function automatic bit cell_loaded(logic [15:0] px, logic [15:0] py);
        longint cx, cy;
        int     ix, iy, ix1, iy1;
        cx  = longint'(px) * longint'(shadow_freq);
        cy  = longint'(py) * longint'(shadow_freq);
        ix  = int'((cx >> 16) % GW);
        iy  = int'((cy >> 16) % GH);
        ix1 = (ix + 1) % GW;
        iy1 = (iy + 1) % GH;
        return loaded[(iy * GW + ix) % TABLE_DEPTH] && loaded[(iy * GW + ix1) % TABLE_DEPTH]
            && loaded[(iy1 * GW + ix) % TABLE_DEPTH]
            && loaded[(iy1 * GW + ix1) % TABLE_DEPTH];
    endfunction

    // Send one item and update the shadow state once it is accepted.
    // Valid stays high after acceptance so that items can follow back to
    // back; idle cycles and wait_idle drop it.
    task automatic send_item(gn2d_op_t op, logic [TABLE_AW-1:0] idx,
                             logic [15:0] gx, logic [15:0] gy,
                             logic [15:0] px, logic [15:0] py);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid         <= 1'b1;
        pix_if.operation     <= op;
        pix_if.grid_index    <= idx;
        pix_if.gradient_x_in <= gx;
        pix_if.gradient_y_in <= gy;
        pix_if.pixel_x       <= px;
        pix_if.pixel_y       <= py;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
        if (op == OP_LOAD)
        begin
            shadow_gx[idx] = gx;
            shadow_gy[idx] = gy;
            loaded[idx]    = 1'b1;
        end
        else
            pending_noise.push_back(predict_noise(px, py));
    endtask

    task automatic load_gradient(int idx, logic [15:0] gx, logic [15:0] gy);
        send_item(OP_LOAD, TABLE_AW'(idx), gx, gy, 16'($urandom), 16'($urandom));
    endtask

    // Evaluate a pixel only if its cell is fully loaded; noise on the
    // ignored fields exercises every bit of them.
    task automatic eval_pixel(logic [15:0] px, logic [15:0] py);
        if (cell_loaded(px, py))
            send_item(OP_EVAL, TABLE_AW'($urandom), 16'($urandom), 16'($urandom), px, py);
    endtask

    // Draw random pixels until one lands in a loaded cell or the tries run out, then evaluate it if its cell is loaded.
    task automatic eval_random_pixel();
        logic [15:0] px, py;
        px = 16'($urandom);
        py = 16'($urandom);
        for (int k = 0; k < 4000 && !cell_loaded(px, py); k++)
        begin
            px = 16'($urandom);
            py = 16'($urandom);
        end
        eval_pixel(px, py);
    endtask

    // Wait until every expected result has arrived, then let the pipeline
    // settle so that a trailing load item has written its tables.
    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        while (pending_noise.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_frequency(logic [FREQ_W-1:0] f);
        wait_idle();
        cfg_if.valid     <= 1'b1;
        cfg_if.frequency <= f;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        shadow_freq = f;
    endtask

    function automatic logic [15:0] rand_gradient();
        case ($urandom_range(5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'($urandom);
            default: return 16'($urandom_range(32768) - 16384);
        endcase
    endfunction

    // Extreme gradients and the pixel corners, at the reset frequency and then at 65536 and 1.
    task automatic test_directed();
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (i < 4 || (i >= GW && i < GW + 4) || i == TABLE_DEPTH - 1)
                load_gradient(i, (i % 2) ? 16'sd16384 : -16'sd16384,
                              (i % 3) ? 16'h7FFF : 16'h8000);
        eval_pixel(16'd0, 16'd0);
        eval_pixel(16'd5, 16'd5);
        eval_pixel(16'd9, 16'd19);
        eval_pixel(16'd15, 16'd3);
        write_frequency(17'd65536);
        load_gradient(TABLE_DEPTH - 2, 16'h7FFF, 16'h7FFF);
        load_gradient(TABLE_DEPTH - GW, 16'h8000, 16'h7FFF);
        load_gradient(TABLE_DEPTH - GW - 1, 16'h7FFF, 16'h8000);
        load_gradient(GW - 1, 16'h8000, 16'h8000);
        load_gradient(0, 16'h7FFF, 16'h7FFF);
        eval_pixel(16'hFFFF, 16'hFFFF);
        eval_pixel(16'd0, 16'd0);
        write_frequency(17'd1);
        eval_pixel(16'hFFFF, 16'hFFFF);
        eval_pixel(16'h8000, 16'h0000);
    endtask

    // Fill a block of the grid at its origin so that random pixels find
    // loaded cells without loading every entry.
    task automatic test_fill_table();
        for (int r = 0; r < FILL_ROWS; r++)
            for (int c = 0; c < FILL_COLS; c++)
                load_gradient(r * GW + c, rand_gradient(), rand_gradient());
    endtask

    // Mostly pixels at the given frequency, mixed with reloads of random entries.
    task automatic test_random(int n, logic [FREQ_W-1:0] f);
        write_frequency(f);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) < 2)
                load_gradient($urandom_range(GW * GH - 1), rand_gradient(), rand_gradient());
            else
                eval_random_pixel();
            if (i == n / 2)
                wait_idle();
        end
    endtask

    // Result checker: compare each accepted result with the oldest one expected.
    always @(posedge clk)
    begin
        noise_res_t exp_r;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_noise.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result noise %0d gray %0d",
                             res_if.noise_value, res_if.gray_level);
            end
            else
            begin
                exp_r = pending_noise.pop_front();
                if (res_if.noise_value !== exp_r.noise || res_if.gray_level !== exp_r.gray)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch noise exp %0d got %0d, gray exp %0d got %0d",
                                 exp_r.noise, res_if.noise_value,
                                 exp_r.gray, res_if.gray_level);
                end
            end
        end
    end

    // Receiver ready, stalling at the rate the current phase asks for.
    always @(posedge clk)
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        shadow_freq = FREQ_RESET;
        pix_if.valid = 1'b0;
        pix_if.operation = OP_LOAD;
        pix_if.grid_index = '0;
        pix_if.gradient_x_in = '0;
        pix_if.gradient_y_in = '0;
        pix_if.pixel_x = '0;
        pix_if.pixel_y = '0;
        res_if.ready = 1'b1;
        cfg_if.valid = 1'b0;
        cfg_if.frequency = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_table();
        test_random(350, 17'(FREQ_RESET));
        send_idle_pct = 82;
        test_random(350, 17'($urandom_range(65536, 1)));
        send_idle_pct = 0;
        recv_stall_pct = 82;
        test_random(350, 17'd0);
        send_idle_pct = 20;
        recv_stall_pct = 20;
        test_random(220, 17'h1FFFF);
        test_random(80, 17'($urandom));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_idle();

        if (mismatches == 0 && pending_noise.size() == 0)
            $display("gradient_noise_2d_pixel test passed");
        else
            $display("gradient_noise_2d_pixel test failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("gradient_noise_2d_pixel test failed");
        $finish;
    end

endmodule

### gradient_noise_2d_pixel.f
hdl/gn2d_pkg.sv
hdl/gn2d_if.sv
hdl/gn2d_ram.sv
hdl/gn2d_coord.sv
hdl/gn2d_blend.sv
hdl/gradient_noise_2d_pixel.sv
dv/tb_gradient_noise_2d_pixel.sv
